// ----- hw/rtl/kmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int POS_W       = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 2;
  localparam int PAT_W       = PATTERN_MAX * BYTE_W;

  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT_LOW  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT_HIGH = 2'd2;

  typedef struct packed {
    logic cfg_write;
    logic build_sel;
    logic build_step;
    logic load_item;
    logic match_step;
    logic go_found;
    logic emit_plain;
    logic emit_found;
  } kmp_cmd_t;

  typedef struct packed {
    logic build_done;
    logic step_done;
    logic full_match;
    logic out_free;
    logic cfg_known;
  } kmp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kmp_text_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kmp_text_if
  import kmp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              stream_start;

  modport source (output valid, output text_byte, output stream_start, input ready);
  modport sink   (input valid, input text_byte, input stream_start, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kmp_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kmp_result_if
  import kmp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             match_found;
  logic [POS_W-1:0] match_start;
  logic [LEN_W-1:0] prefix_length;

  modport source (output valid, output match_found, output match_start,
                  output prefix_length, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input prefix_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kmp_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kmp_cfg_if
  import kmp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kmp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmp_ctrl
  import kmp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire kmp_sts_t sts_i,
  output kmp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_MATCH = 4'b0100,
    ST_FOUND = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cfg_ready_o = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          if (sts_i.cfg_known) begin
            cmd_o.cfg_write = 1'b1;
            state_d         = ST_BUILD;
          end
        end else if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_MATCH;
        end
      end
      ST_BUILD: begin
        cmd_o.build_sel = 1'b1;
        if (sts_i.build_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.build_step = 1'b1;
        end
      end
      ST_MATCH: begin
        if (!sts_i.step_done) begin
          cmd_o.match_step = 1'b1;
        end else if (sts_i.full_match) begin
          cmd_o.go_found = 1'b1;
          state_d        = ST_FOUND;
        end else if (sts_i.out_free) begin
          cmd_o.emit_plain = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FOUND: begin
        if (sts_i.out_free) begin
          cmd_o.emit_found = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kmp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmp_datapath
  import kmp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire kmp_cmd_t              cmd_i,
  output kmp_sts_t                   sts_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [BYTE_W-1:0]     text_byte_i,
  input  wire logic                  stream_start_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic                       match_found_o,
  output logic [POS_W-1:0]           match_start_o,
  output logic [LEN_W-1:0]           prefix_length_o
);

  logic [LEN_W-1:0]      len_q;
  logic [CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [LEN_W-1:0]      fb_q [PATTERN_MAX];
  logic [LEN_W-1:0]      bi_q, bk_q;
  logic [LEN_W-1:0]      prefix_q, j_q;
  logic [POS_W-1:0]      pos_q, cur_pos_q;
  logic [BYTE_W-1:0]     c_q;
  logic                  out_valid_q, found_q;
  logic [POS_W-1:0]      start_q;
  logic [LEN_W-1:0]      plen_q;

  logic [PAT_W-1:0]  pat;
  logic [LEN_W-1:0]  m;
  logic [IDX_W-1:0]  rd_addr;
  logic [LEN_W-1:0]  fb_rd;
  logic [BYTE_W-1:0] pk, pi, pj;
  logic              bk_miss, j_miss, j_hit;
  logic [LEN_W-1:0]  bk_next, j_next, j0;
  logic [POS_W-1:0]  pos_cur;

  assign pat = {pat_high_q, pat_low_q};
  assign m   = (len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_q;

  assign rd_addr = cmd_i.build_sel ? IDX_W'(bk_q - 1'b1) : IDX_W'(j_q - 1'b1);
  assign fb_rd   = fb_q[rd_addr];

  assign pk = pat[bk_q[IDX_W-1:0]*BYTE_W +: BYTE_W];
  assign pi = pat[bi_q[IDX_W-1:0]*BYTE_W +: BYTE_W];
  assign pj = pat[j_q[IDX_W-1:0]*BYTE_W +: BYTE_W];

  assign bk_miss = (bk_q != '0) && (pk != pi);
  assign bk_next = bk_q + LEN_W'(pk == pi);

  assign j_miss = (j_q != '0) && (c_q != pj);
  assign j_hit  = (m != '0) && (c_q == pj);
  assign j_next = (m == '0) ? '0 : (j_q + LEN_W'(j_hit));

  assign j0      = (stream_start_i || (prefix_q >= m)) ? '0 : prefix_q;
  assign pos_cur = stream_start_i ? '0 : pos_q;

  assign sts_o.build_done = (bi_q >= m);
  assign sts_o.step_done  = !j_miss;
  assign sts_o.full_match = (m != '0) && (j_next == m);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.cfg_known  = (cfg_addr_i == REG_LENGTH) || (cfg_addr_i == REG_PAT_LOW) ||
                            (cfg_addr_i == REG_PAT_HIGH);

  // configuration, table and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pat_low_q  <= '0;
      pat_high_q <= '0;
      fb_q       <= '{default: '0};
      bi_q       <= '0;
      bk_q       <= '0;
      prefix_q   <= '0;
      pos_q      <= '0;
    end else begin
      if (cmd_i.cfg_write) begin
        case (cfg_addr_i)
          REG_LENGTH:   len_q      <= cfg_data_i[LEN_W-1:0];
          REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
          REG_PAT_HIGH: pat_high_q <= cfg_data_i;
          default:      len_q      <= len_q;
        endcase
        bi_q     <= LEN_W'(1);
        bk_q     <= '0;
        prefix_q <= '0;
      end
      if (cmd_i.build_step) begin
        if (bk_miss) begin
          bk_q <= fb_rd;
        end else begin
          fb_q[bi_q[IDX_W-1:0]] <= bk_next;
          bk_q                  <= bk_next;
          bi_q                  <= bi_q + 1'b1;
        end
      end
      if (cmd_i.load_item) begin
        pos_q <= pos_cur + 1'b1;
      end
      if (cmd_i.emit_plain) begin
        prefix_q <= j_next;
      end
      if (cmd_i.emit_found) begin
        prefix_q <= fb_rd;
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      c_q       <= text_byte_i;
      j_q       <= j0;
      cur_pos_q <= pos_cur;
    end else if (cmd_i.match_step) begin
      j_q <= fb_rd;
    end else if (cmd_i.go_found) begin
      j_q <= j_next;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_plain || cmd_i.emit_found) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_plain) begin
      found_q <= 1'b0;
      start_q <= '0;
      plen_q  <= j_next;
    end else if (cmd_i.emit_found) begin
      found_q <= 1'b1;
      start_q <= cur_pos_q - POS_W'(m) + 1'b1;
      plen_q  <= fb_rd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_found_o   = found_q;
  assign match_start_o   = start_q;
  assign prefix_length_o = plen_q;

  a_prefix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q <= LEN_W'(PATTERN_MAX))
    else $error("matched prefix beyond pattern size");

  a_build_k_below_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.build_step |-> (bk_q < bi_q))
    else $error("build prefix not below build index");

  a_found_at_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_found |-> ((j_q == m) && (m != '0)))
    else $error("match reported without full prefix");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_plain || cmd_i.emit_found) |=> out_valid_q)
    else $error("result lost at output register");

endmodule

`default_nettype wire

// ----- hw/rtl/kmp_stream_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Flow: an accepted word is loaded into the working registers and falls back through the
//   failure table until its byte matches or the prefix is empty; a full match goes through
//   ST_FOUND, and the result is registered once the output register is free.
// Input: a new word is accepted only after the last result is registered; a config write to
//   a known register rebuilds the table (single read port); no text accepted meanwhile.
// Reset: pattern, length, table, prefix and position clear to zero; output empty.
module kmp_stream_matcher
  import kmp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  kmp_cfg_if.sink       cfg_i,
  kmp_text_if.sink      text_i,
  kmp_result_if.source  result_o
);

  kmp_cmd_t cmd;
  kmp_sts_t sts;

  kmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .in_valid_i  (text_i.valid),
    .in_ready_o  (text_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kmp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_addr_i      (cfg_i.addr),
    .cfg_data_i      (cfg_i.data),
    .text_byte_i     (text_i.text_byte),
    .stream_start_i  (text_i.stream_start),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .match_found_o   (result_o.match_found),
    .match_start_o   (result_o.match_start),
    .prefix_length_o (result_o.prefix_length)
  );

endmodule

`default_nettype wire

// ----- dv/kmp_match_checker.sv -----
`timescale 1ns / 1ps

module kmp_match_checker
  import kmp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  kmp_cfg_if    cfg_i,
  kmp_text_if   text_i,
  kmp_result_if result_i,
  output int    mismatches_o,
  output int    pending_o
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] prefix;
  } match_result_t;

  logic [LEN_W-1:0]      len_q;
  logic [CFG_DATA_W-1:0] pat_lo_q;
  logic [CFG_DATA_W-1:0] pat_hi_q;
  logic [LEN_W-1:0]      prefix_q;
  logic [POS_W-1:0]      pos_q;
  logic [LEN_W-1:0]      fallback_q [PATTERN_MAX];
  match_result_t         predicted_q [$];
  int                    bad_cnt;

  function automatic int active_len();
    return (len_q > PATTERN_MAX) ? PATTERN_MAX : int'(len_q);
  endfunction

  function automatic logic [BYTE_W-1:0] pat_byte(int idx);
    int i;
    i = idx & 15;
    if (i < 8) return pat_lo_q[(i % 8) * 8 +: 8];
    return pat_hi_q[(i % 8) * 8 +: 8];
  endfunction

  // one text word through the matcher: advance, fall back, report
  function automatic match_result_t scan_byte(logic [BYTE_W-1:0] c, logic restart);
    match_result_t    r;
    int               m;
    int               j;
    logic [POS_W-1:0] at;
    r = '0;
    if (restart) begin
      prefix_q = '0;
      pos_q    = '0;
    end
    at = pos_q;
    m  = active_len();
    j  = prefix_q;
    if (j >= m) j = 0;
    if (m > 0) begin
      while (j > 0 && c != pat_byte(j)) j = fallback_q[j-1];
      if (c == pat_byte(j)) j++;
      if (j == m) begin
        r.found = 1'b1;
        r.start = at - POS_W'(m) + 1;
        j       = fallback_q[j-1];
      end
    end else begin
      j = 0;
    end
    prefix_q = LEN_W'(j);
    pos_q    = at + 1;
    r.prefix = LEN_W'(j);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_result_t got;
    match_result_t want;
    logic          known;
    int            m;
    int            k;
    if (!rst_ni) begin
      len_q    = '0;
      pat_lo_q = '0;
      pat_hi_q = '0;
      prefix_q = '0;
      pos_q    = '0;
      for (int i = 0; i < PATTERN_MAX; i++) fallback_q[i] = '0;
      predicted_q.delete();
      bad_cnt = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        known = 1'b1;
        case (cfg_i.addr)
          REG_LENGTH:   len_q    = cfg_i.data[LEN_W-1:0];
          REG_PAT_LOW:  pat_lo_q = cfg_i.data;
          REG_PAT_HIGH: pat_hi_q = cfg_i.data;
          default:      known    = 1'b0;
        endcase
        if (known) begin
          m = active_len();
          k = 0;
          for (int i = 0; i < PATTERN_MAX; i++) fallback_q[i] = '0;
          for (int i = 1; i < m; i++) begin
            while (k > 0 && pat_byte(k) != pat_byte(i)) k = fallback_q[k-1];
            if (pat_byte(k) == pat_byte(i)) k++;
            fallback_q[i] = LEN_W'(k);
          end
          prefix_q = '0;
        end
      end
      if (result_i.valid && result_i.ready) begin
        got.found  = result_i.match_found;
        got.start  = result_i.match_start;
        got.prefix = result_i.prefix_length;
        if (predicted_q.size() == 0) begin
          bad_cnt++;
          $display("%0t: unexpected result word found=%0h start=%0h prefix=%0d",
                   $time, got.found, got.start, got.prefix);
        end else begin
          want = predicted_q.pop_front();
          if (got.found !== want.found) begin
            bad_cnt++;
            $display("%0t: match_found expected %0h actual %0h",
                     $time, want.found, got.found);
          end
          if (got.start !== want.start) begin
            bad_cnt++;
            $display("%0t: match_start expected %0h actual %0h",
                     $time, want.start, got.start);
          end
          if (got.prefix !== want.prefix) begin
            bad_cnt++;
            $display("%0t: prefix_length expected %0d actual %0d",
                     $time, want.prefix, got.prefix);
          end
        end
      end
      if (text_i.valid && text_i.ready)
        predicted_q.insert(predicted_q.size(),
                           scan_byte(text_i.text_byte, text_i.stream_start));
    end
    mismatches_o <= bad_cnt;
    pending_o    <= predicted_q.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import kmp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
  localparam int TOTAL_WORDS  = 850;
  localparam int DRAIN_CYCLES = 24;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_fire  = 1'b0;
  logic             text_fire = 1'b0;
  logic             quiet     = 1'b0;
  int               mismatches;
  int               pending;
  int               words_sent = 0;
  int               hold_cnt   = 0;
  logic [7:0]       pat [PATTERN_MAX];
  logic [7:0]       sym_a;
  logic [7:0]       sym_b;
  logic [LEN_W-1:0] pat_len = '0;
  logic [7:0]       text_plan [$];

  kmp_cfg_if    cfg_bus ();
  kmp_text_if   text_bus ();
  kmp_result_if result_bus ();

  kmp_stream_matcher dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .text_i  (text_bus),
    .result_o(result_bus)
  );

  kmp_match_checker match_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_i       (cfg_bus),
    .text_i      (text_bus),
    .result_i    (result_bus),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cfg_fire  <= cfg_bus.valid && cfg_bus.ready;
    text_fire <= text_bus.valid && text_bus.ready;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure
  initial begin
    result_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        result_bus.ready = 1'b0;
        hold_cnt--;
      end else begin
        result_bus.ready = 1'b1;
        if (!quiet && $urandom_range(0, 99) < 25) hold_cnt = gap_len();
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.addr  = idx;
    cfg_bus.data  = val;
    cfg_bus.valid = 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_word(input logic [7:0] b, input logic restart);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 30) begin
      gap = gap_len();
      text_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_bus.text_byte    = b;
    text_bus.stream_start = restart;
    text_bus.valid        = 1'b1;
    do @(negedge clk); while (!text_fire);
    words_sent++;
  endtask

  task automatic drain();
    text_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_pattern();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] len_word;
    logic                  len_first;
    int                    r;
    r = $urandom_range(0, 99);
    if (r < 8)       pat_len = '0;
    else if (r < 18) pat_len = LEN_W'($urandom_range(17, 31));
    else if (r < 30) pat_len = LEN_W'(PATTERN_MAX);
    else if (r < 40) pat_len = LEN_W'(1);
    else             pat_len = LEN_W'($urandom_range(2, 15));
    sym_a = 8'($urandom);
    sym_b = ($urandom_range(0, 4) == 0) ? sym_a : 8'($urandom);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ($urandom_range(0, 9) == 0) pat[i] = 8'($urandom);
      else                           pat[i] = $urandom_range(0, 1) ? sym_a : sym_b;
    end
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = pat[i];
      hi[i*8 +: 8] = pat[i+8];
    end
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = pat_len;
    len_first = $urandom_range(0, 1);
    if (len_first) write_reg(REG_LENGTH, len_word);
    write_reg(REG_PAT_LOW, lo);
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_PAT_HIGH, hi);
    if (!len_first) write_reg(REG_LENGTH, len_word);
  endtask

  function automatic void plan_add(input logic [7:0] b);
    text_plan.insert(text_plan.size(), b);
  endfunction

  // mostly pattern copies and prefixes so that matches and fallbacks happen
  function automatic void refill_plan();
    int m;
    int r;
    int n;
    m = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    if (m == 0) m = 4;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      for (int i = 0; i < m; i++) plan_add(pat[i]);
    end else if (r < 70) begin
      n = $urandom_range(1, m);
      for (int i = 0; i < n - 1; i++) plan_add(pat[i]);
      plan_add($urandom_range(0, 1) ? sym_a : sym_b);
    end else if (r < 85) begin
      repeat ($urandom_range(1, 4)) plan_add($urandom_range(0, 1) ? sym_a : sym_b);
    end else begin
      repeat ($urandom_range(1, 3)) plan_add(8'($urandom));
    end
  endfunction

  initial begin
    int n;
    cfg_bus.valid         = 1'b0;
    cfg_bus.addr          = '0;
    cfg_bus.data          = '0;
    text_bus.valid        = 1'b0;
    text_bus.text_byte    = '0;
    text_bus.stream_start = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero length never matches
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    settle();

    write_reg(REG_PAT_LOW, 64'h0000_0000_6261_6261);
    write_reg(REG_LENGTH, 64'd4);
    write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    // overlapping matches
    for (int i = 0; i < 6; i++) send_word((i % 2) ? 8'h62 : 8'h61, i == 0);
    // restart in the middle of a partial match
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b1);
    send_word(8'h61, 1'b0);
    settle();

    // oversized length clamps to the full pattern, one repeated byte
    write_reg(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 17; i++) send_word(8'hFF, i == 0);

    while (words_sent < TOTAL_WORDS) begin
      settle();
      program_pattern();
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 110);
      text_plan.delete();
      for (int i = 0; i < n; i++) begin
        if (text_plan.size() == 0) refill_plan();
        send_word(text_plan.pop_front(),
                  (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 99) < 3);
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    quiet = 1'b0;
    settle();
    if (mismatches == 0)
      $display("kmp_stream_matcher regression: pass");
    else
      $display("kmp_stream_matcher regression: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("kmp_stream_matcher regression: fail");
    $finish;
  end

endmodule
